// ===== hdl/atsl_pkg.sv =====
// Package for the atanh series natural log block.
// Holds the sequencer state type and fixed-point constants; no dependencies.
`default_nettype none
package atsl_pkg;
    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_ZZ, ST_PW_MUL, ST_PW_SQ, ST_TERM_DIV,
        ST_TERM_ADD, ST_TERM_MUL, ST_DONE
    } state_t;

    localparam int QF = 62;
    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
    localparam logic [47:0] X_ONE = 48'h1_0000;
endpackage
`default_nettype wire

// ===== hdl/atanh_series_natural_log.sv =====
// Top level of the atanh series natural log: sequencer, shared divider and adder.
// Depends on atsl_pkg and atsl_mul.
//
// channel  dir  tdata fields (low to high)
// s_       in   x_value[47:0], first_term[72:48], end_term[97:73]
// m_       out  partial_log[63:0]
//
// One item: z by restoring divide, z*z, the power by square-and-multiply over
// the bits of 2*first+1, then per term a restoring divide, one add and a
// multiply; the loop ends early once the power reaches zero. Synchronous
// active-low reset returns to idle. s_axis_tready is high only when idle; a
// finished result waits in the output register and holds the sequencer in done.
`default_nettype none
module atanh_series_natural_log #(
    parameter int TERM_INDEX_BITS      = 24,
    parameter int RESULT_FRACTION_BITS = 48
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [103:0] s_axis_tdata,  // x_value, first_term, end_term
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata   // partial_log
);
    import atsl_pkg::*;

    localparam logic [25:0] LIM = (TERM_INDEX_BITS > 25) ? 26'h200_0000
                                                        : 26'(64'd1 << TERM_INDEX_BITS);
    localparam int SH = QF - RESULT_FRACTION_BITS;

    state_t state_reg, state_next;
    logic [24:0] first_c, end_c;
    logic [25:0] n_reg, n_next, end_reg, end_next;
    logic [26:0] e_reg, e_next;
    logic        neg_reg, neg_next;
    logic [63:0] zm_reg, zm_next, zz_reg, zz_next, p_reg, p_next, b_reg, b_next;
    logic [63:0] acc_reg, acc_next, out_reg, out_next;
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next, den_reg, den_next;
    logic [6:0]  k_reg, k_next;
    logic        ov_reg, ov_next;
    logic        mstart;
    logic [63:0] ma, mb, mprod;
    logic        mdone;
    logic [64:0] r_sh;
    logic [5:0]  bit_idx;
    logic [64:0] r_in;
    logic [63:0] t, mag, cap;
    logic [64:0] sum;
    logic [47:0] xv;

    atsl_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mstart), .a(ma), .b(mb),
        .done(mdone), .prod(mprod)
    );

    assign xv = s_axis_tdata[47:0];
    assign first_c = s_axis_tdata[72:48];
    assign end_c   = s_axis_tdata[97:73];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;
    assign r_sh = {r_reg[63:0], 1'b0};
    assign bit_idx = 6'd63 - k_reg[5:0];
    assign r_in = {r_reg[63:0], p_reg[bit_idx]};
    assign t = q_reg >> SH;
    assign sum = {1'b0, acc_reg} + {1'b0, t};

    always_comb begin
        state_next = state_reg;
        n_next = n_reg; end_next = end_reg; e_next = e_reg; neg_next = neg_reg;
        zm_next = zm_reg; zz_next = zz_reg; p_next = p_reg; b_next = b_reg;
        acc_next = acc_reg; out_next = out_reg; q_next = q_reg; r_next = r_reg;
        den_next = den_reg; k_next = k_reg; ov_next = ov_reg;
        mstart = 1'b0; ma = p_reg; mb = b_reg;
        cap = neg_reg ? MAG_CAP : MAG_CAP - 64'd1;
        mag = (acc_reg > (cap >> 1)) ? cap : (acc_reg << 1);
        if (ov_reg && m_axis_tready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_next   = ({1'b0, first_c} > LIM) ? LIM : {1'b0, first_c};
                    end_next = ({1'b0, end_c} > LIM) ? LIM : {1'b0, end_c};
                    neg_next = xv < X_ONE;
                    acc_next = '0;
                    r_next   = {17'd0, (xv >= X_ONE) ? xv - X_ONE : X_ONE - xv};
                    den_next = {17'd0, xv} + {17'd0, X_ONE};
                    q_next   = '0;
                    k_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (k_reg == 7'd0 && r_reg >= den_reg) begin
                    zm_next = ONE_Q62; k_next = 7'd63;
                end else if (k_reg == 7'd62) begin
                    zm_next = q_reg;
                    k_next = 7'd63;
                end else if (k_reg != 7'd63) begin
                    r_next = (r_sh >= den_reg) ? r_sh - den_reg : r_sh;
                    q_next = {q_reg[62:0], r_sh >= den_reg};
                    k_next = k_reg + 7'd1;
                end
                if (k_reg == 7'd63) begin
                    if (n_reg < end_reg) begin
                        ma = zm_reg; mb = zm_reg; mstart = 1'b1;
                        state_next = ST_ZZ;
                    end else state_next = ST_DONE;
                end
            end
            ST_ZZ: if (mdone) begin
                zz_next = mprod; p_next = ONE_Q62; b_next = zm_reg;
                e_next = {n_reg, 1'b1};
                ma = ONE_Q62; mb = zm_reg; mstart = 1'b1;
                state_next = ST_PW_MUL;
            end
            ST_PW_MUL: if (mdone) begin
                if (e_reg[0]) p_next = mprod;
                ma = b_reg; mb = b_reg; mstart = 1'b1;
                state_next = ST_PW_SQ;
            end
            ST_PW_SQ: if (mdone) begin
                b_next = mprod;
                e_next = e_reg >> 1;
                if (e_next == '0) begin
                    state_next = ST_TERM_DIV;
                    r_next = '0; q_next = '0; k_next = '0;
                    den_next = {38'd0, n_reg, 1'b1};
                end else begin
                    ma = p_reg; mb = mprod; mstart = 1'b1;
                    state_next = ST_PW_MUL;
                end
            end
            ST_TERM_DIV: begin
                if (n_reg >= end_reg || p_reg == '0) state_next = ST_DONE;
                else if (k_reg[6]) state_next = ST_TERM_ADD;
                else begin
                    r_next = (r_in >= den_reg) ? r_in - den_reg : r_in;
                    q_next = {q_reg[62:0], r_in >= den_reg};
                    k_next = k_reg + 7'd1;
                end
            end
            ST_TERM_ADD: begin
                acc_next = (sum > {1'b0, MAG_CAP}) ? MAG_CAP : sum[63:0];
                ma = p_reg; mb = zz_reg; mstart = 1'b1;
                state_next = ST_TERM_MUL;
            end
            ST_TERM_MUL: if (mdone) begin
                p_next = mprod;
                n_next = n_reg + 26'd1;
                r_next = '0; q_next = '0; k_next = '0;
                den_next = {38'd0, n_next, 1'b1};
                state_next = ST_TERM_DIV;
            end
            ST_DONE: begin
                if (!ov_reg) begin
                    out_next = neg_reg ? 64'd0 - mag : mag;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        n_reg <= n_next; end_reg <= end_next; e_reg <= e_next; neg_reg <= neg_next;
        zm_reg <= zm_next; zz_reg <= zz_next; p_reg <= p_next; b_reg <= b_next;
        acc_reg <= acc_next; out_reg <= out_next; q_reg <= q_next; r_reg <= r_next;
        den_reg <= den_next; k_reg <= k_next;
    end
endmodule
`default_nettype wire

// ===== hdl/atsl_mul.sv =====
// Sequential 64x64 Q62 multiplier: four 32x32 partial products, one per cycle.
// Depends on atsl_pkg.
`default_nettype none
module atsl_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      prod
);
    import atsl_pkg::*;

    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  a_reg, b_reg;
    logic [31:0]  opa, opb;
    logic [63:0]  pp_reg;
    logic [1:0]   pidx_reg;
    logic         pvalid_reg;
    logic [127:0] pp_sh;

    always_comb begin
        opa = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        opb = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
    end

    always_comb begin
        unique case (pidx_reg)
            2'd0: pp_sh = {64'd0, pp_reg};
            2'd1, 2'd2: pp_sh = {32'd0, pp_reg, 32'd0};
            default: pp_sh = {pp_reg, 64'd0};
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        done      = busy_reg && (step_reg == 3'd5);
        if (start) begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (pvalid_reg) acc_next = acc_reg + pp_sh;
            if (step_reg == 3'd5) busy_next = 1'b0;
            step_next = step_reg + 3'd1;
        end
    end

    assign prod = acc_reg[QF +: 64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            pvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            pvalid_reg <= busy_reg && !start && step_reg < 3'd4;
        end
        acc_reg  <= acc_next;
        pp_reg   <= opa * opb;
        pidx_reg <= step_reg[1:0];
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for atanh_series_natural_log: random and directed items checked against
// an internal predictor of the partial ln(x) series. Depends on atsl_pkg and the RTL.
`default_nettype none
module testbench;
    import atsl_pkg::*;

    localparam int          IDLE_LIMIT = 200000;
    localparam logic [24:0] TERM_LIM   = 25'd1 << 24;

    typedef struct packed {
        logic [24:0] end_term;
        logic [24:0] first_term;
        logic [47:0] x_value;
    } log_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;  // x_value, first_term, end_term
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;       // partial_log

    log_req_t    req_queue[$];
    logic [63:0] log_expected[$];
    int          n_sent = 0, n_results = 0, n_errors = 0, idle_cycles = 0, cyc = 0;
    int          burst_left = 0, gap_left = 0, hold_left = 0;
    bit          hold_done = 0;

    atanh_series_natural_log u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    function automatic logic [63:0] ratio_mag(input logic [47:0] xv);
        logic [63:0]  num, den;
        logic [127:0] q;
        num = (xv >= X_ONE) ? 64'(xv - X_ONE) : 64'(X_ONE - xv);
        den = 64'(xv) + 64'(X_ONE);
        if (num >= den) return ONE_Q62;
        q = {num, 62'd0} / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic [63:0] series_log(input log_req_t r);
        logic [63:0] first, last, zm, zz, pw, base, ex, acc, t, mag, cap, n;
        bit          neg;
        neg   = r.x_value < X_ONE;
        first = (r.first_term > TERM_LIM) ? 64'(TERM_LIM) : 64'(r.first_term);
        last  = (r.end_term > TERM_LIM) ? 64'(TERM_LIM) : 64'(r.end_term);
        acc   = '0;
        if (first < last) begin
            zm   = ratio_mag(r.x_value);
            zz   = q62_mul(zm, zm);
            pw   = ONE_Q62;
            base = zm;
            ex   = 2 * first + 1;
            while (ex != 0) begin
                if (ex[0]) pw = q62_mul(pw, base);
                base = q62_mul(base, base);
                ex   = ex >> 1;
            end
            for (n = first; n < last && pw != 0; n++) begin
                t = (pw / (2 * n + 1)) >> (QF - 48);
                if (t > MAG_CAP - acc) acc = MAG_CAP;
                else acc = acc + t;
                pw = q62_mul(pw, zz);
            end
        end
        cap = neg ? MAG_CAP : MAG_CAP - 1;
        mag = (acc > (cap >> 1)) ? cap : (acc << 1);
        return neg ? -mag : mag;
    endfunction

    task automatic add_req(input logic [47:0] x, input logic [24:0] f, input logic [24:0] e);
        log_req_t r;
        r.x_value    = x;
        r.first_term = f;
        r.end_term   = e;
        req_queue = {req_queue, r};
    endtask

    task automatic report_mismatch(input logic [63:0] got, input logic [63:0] want);
        n_errors++;
        $display("ERROR t=%0t partial_log got %h expected %h", $time, got, want);
    endtask

    // driver: bursts with random gaps, hold data until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                log_expected = {log_expected, series_log(req_queue.pop_front())};
                n_sent++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, req_queue[0]};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: long hold-off once, else a phase-dependent stall pattern
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_sent == 20) begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
        if (!aresetn || hold_left > 0 || (!hold_done && n_sent == 20))
            m_axis_tready <= 1'b0;
        else if (cyc[11])
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (log_expected.size() == 0) begin
                n_errors++;
                $display("ERROR t=%0t unexpected result %h", $time, m_axis_tdata);
            end else begin
                logic [63:0] want;
                want = log_expected.pop_front();
                if (m_axis_tdata !== want) report_mismatch(m_axis_tdata, want);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [47:0] x;
        logic [24:0] f;
        int          k;
        add_req(48'h1_0000, 25'd0, 25'd6);
        add_req(48'h0, 25'd0, 25'd6);
        add_req(48'h0, 25'd3, 25'd5);
        add_req(48'h2_0000, 25'd0, 25'd10);
        add_req(48'hFFFF_FFFF_FFFF, 25'd0, 25'd4);
        add_req(48'h1, 25'd0, 25'd4);
        add_req(48'h8000_0000_0000, 25'd0, 25'd3);
        add_req(48'h3_0000, 25'd5, 25'd3);
        add_req(48'h3_0000, 25'd7, 25'd7);
        add_req(48'h1_0001, 25'd0, TERM_LIM);
        add_req(48'hFFFF, 25'd0, TERM_LIM);
        add_req(48'h1_0100, TERM_LIM - 25'd2, 25'h1FF_FFFF);
        add_req(48'h5_0000, 25'h1FF_FFFF, 25'h1FF_FFFF);
        add_req(48'hAAAA_AAAA_AAAA, 25'h155_5555, 25'h0AA_AAAA);
        add_req(48'h5555_5555_5555, TERM_LIM - 25'd1, TERM_LIM);
        add_req(48'h8000, 25'd2, 25'd9);
        for (k = 0; k < 100; k++) begin
            case ($urandom_range(0, 5))
                0: begin
                    x = 48'h1_0000 + 48'($urandom_range(0, 511)) - 48'd256;
                    f = ($urandom_range(0, 3) == 0) ? 25'($urandom_range(0, 25'h1FF_FFFF))
                                                    : 25'($urandom_range(0, 20));
                    add_req(x, f, 25'($urandom_range(0, 25'h1FF_FFFF)));
                end
                1: begin
                    x = 48'({$urandom, $urandom});
                    f = 25'($urandom_range(0, 25'h1FF_FFFF));
                    add_req(x, f, f + 25'($urandom_range(0, 10)));
                end
                2: add_req(48'($urandom_range(0, 3)), 25'($urandom_range(0, 4)),
                           25'($urandom_range(0, 12)));
                3: add_req(48'($urandom_range(0, 32'h20_0000)),
                           25'h1FF_FFFF - 25'($urandom_range(0, 8)),
                           25'h1FF_FFFF - 25'($urandom_range(0, 8)));
                default: begin
                    x = 48'({$urandom, $urandom} >> $urandom_range(16, 63));
                    f = 25'($urandom_range(2, 40));
                    add_req(x, f, f + 25'($urandom_range(0, 12)) - 25'd2);
                end
            endcase
        end
        k = req_queue.size();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        while (n_sent < k || log_expected.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d items (extremes of x, empty and clamped ranges, early stop);",
                 n_sent);
        $display("checked %0d results under bursty input and stalled output.", n_results);
        if (n_errors == 0 && log_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/atsl_pkg.sv
hdl/atsl_mul.sv
hdl/atanh_series_natural_log.sv
tb/sv/testbench.sv
